// ----- src/cscs_pkg.sv -----
// Package for the cycle-stepped CPU subset core.
// Holds sequence codes, opcodes, flag masks and vector addresses; no dependencies.
`default_nettype none
package cscs_pkg;
	localparam int ADDR_BITS = 16;

	localparam logic [2:0] SEQ_IDLE     = 3'd0;
	localparam logic [2:0] SEQ_RESET    = 3'd1;
	localparam logic [2:0] SEQ_BRK      = 3'd2;
	localparam logic [2:0] SEQ_ORA_ZP   = 3'd3;
	localparam logic [2:0] SEQ_ORA_XIND = 3'd4;
	localparam logic [2:0] SEQ_ORA_INDY = 3'd5;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] OPC_BRK      = 8'h00;
	localparam logic [7:0] OPC_ORA_XIND = 8'h01;
	localparam logic [7:0] OPC_ORA_ZP   = 8'h05;
	localparam logic [7:0] OPC_ORA_INDY = 8'h11;

	localparam logic [7:0] FLAG_N = 8'h80;
	localparam logic [7:0] FLAG_B = 8'h10;
	localparam logic [7:0] FLAG_Z = 8'h02;

	localparam logic [15:0] VEC_RES_LO = 16'hFFFC;
	localparam logic [15:0] VEC_RES_HI = 16'hFFFD;
	localparam logic [15:0] VEC_BRK_LO = 16'hFFFE;
	localparam logic [15:0] VEC_BRK_HI = 16'hFFFF;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	localparam logic CFG_X = 1'b0;
	localparam logic CFG_Y = 1'b1;

	// One memory access requested by the sequencer.
	typedef struct packed {
		logic        en;
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;
endpackage
`default_nettype wire

// ----- src/cscs_mem.sv -----
// Byte memory of the core: one synchronous port with registered read data.
// Depends on cscs_pkg for the request type and the address width.
`default_nettype none
module cscs_mem import cscs_pkg::*; (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output logic [7:0]    rdata
);
	logic [7:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.wr) begin
				mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
			end else begin
				rdata <= mem[req.addr[ADDR_BITS-1:0]];
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/cycle_stepped_cpu_subset_core.sv -----
// Cycle-stepped 8-bit CPU subset core (reset sequence, BRK, ORA zp/(zp,X)/(zp),Y).
// Each transaction issues its memory access on the accept cycle and uses the read
// data in the next cycle, when the result is formed. A new transaction is not
// accepted while one is in progress or while a result waits for out_ready.
// Reset clears the core's state registers and starts the 7-tick reset sequence;
// memory and the read-data hold register are not cleared.
`default_nettype none
module cycle_stepped_cpu_subset_core import cscs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] mem_address,
	input  wire logic [7:0]  mem_write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       mem_read_data,
	output logic [15:0]      prog_count,
	output logic [7:0]       accumulator,
	output logic [7:0]       stack_ptr,
	output logic [7:0]       status_flags,
	output logic             busy_res,
	output logic             fault,
	output logic [7:0]       fault_opcode,
	output logic [31:0]      cycle_count
);
	logic [7:0]  x_q, y_q, acc_q, sp_q, p_q, fcode_q;
	logic [15:0] pc_q, alat_q;
	logic [31:0] cyc_q;
	logic [2:0]  kind_q, step_q;
	logic        pcross_q, fault_q;
	logic        busy_q;      // result-forming cycle of a transaction
	logic [1:0]  op_s1;
	logic        tick_s1;     // tick that really advances the CPU
	mem_req_t    req;
	logic [7:0]  rdata;
	logic [2:0]  nstep;
	logic [7:0]  rdata_hold;

	cscs_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

	assign in_ready = !busy_q && (!out_valid || out_ready);
	assign nstep = step_q + 3'd1;

	// Memory access for the transaction being accepted.
	always_comb begin
		req = '0;
		if (in_valid && in_ready) begin
			if (op == OP_WRITE) begin
				req = '{en: 1'b1, wr: 1'b1, addr: mem_address, wdata: mem_write_data};
			end else if (op == OP_READ) begin
				req = '{en: 1'b1, wr: 1'b0, addr: mem_address, wdata: 8'h00};
			end else if (op == OP_TICK && !fault_q) begin
				req.en = 1'b1;
				if (kind_q == SEQ_IDLE) begin
					req.addr = pc_q;
				end else begin
					case (kind_q)
						SEQ_RESET: begin
							req.addr = (nstep == 3'd6) ? VEC_RES_LO : VEC_RES_HI;
						end
						SEQ_BRK: begin
							case (nstep)
								3'd1: req.addr = pc_q;
								3'd2: req = '{1'b1, 1'b1, {STACK_PAGE, sp_q}, pc_q[15:8]};
								3'd3: req = '{1'b1, 1'b1, {STACK_PAGE, sp_q}, pc_q[7:0]};
								3'd4: req = '{1'b1, 1'b1, {STACK_PAGE, sp_q}, p_q};
								3'd5: req.addr = VEC_BRK_LO;
								default: req.addr = VEC_BRK_HI;
							endcase
						end
						SEQ_ORA_ZP: begin
							req.addr = (nstep == 3'd1) ? pc_q : {8'h00, alat_q[7:0]};
						end
						SEQ_ORA_XIND: begin
							case (nstep)
								3'd1: req.addr = pc_q;
								3'd3: req.addr = {8'h00, alat_q[7:0]};
								3'd4: req.addr = {8'h00, alat_q[7:0] + 8'd1};
								default: req.addr = alat_q;
							endcase
						end
						SEQ_ORA_INDY: begin
							case (nstep)
								3'd1: req.addr = pc_q;
								3'd2: req.addr = {8'h00, alat_q[7:0]};
								3'd3: req.addr = {8'h00, alat_q[7:0] + 8'd1};
								default: req.addr = alat_q;
							endcase
						end
						default: req.en = 1'b0;
					endcase
				end
			end
		end
	end

	// The step counter is left as it is when a sequence ends; a fetch of a
	// supported opcode clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; acc_q <= '0; sp_q <= '0; p_q <= '0;
			fcode_q <= '0; pc_q <= '0; alat_q <= '0; cyc_q <= '0;
			kind_q <= SEQ_RESET; step_q <= '0; pcross_q <= 1'b0; fault_q <= 1'b0;
			busy_q <= 1'b0; op_s1 <= OP_TICK; tick_s1 <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_X) x_q <= cfg_wdata;
				else y_q <= cfg_wdata;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (in_valid && in_ready) begin
				busy_q  <= 1'b1;
				op_s1   <= op;
				tick_s1 <= (op == OP_TICK) && !fault_q;
			end
			if (busy_q) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
				if (tick_s1) begin
					if (kind_q == SEQ_IDLE) begin
						pc_q <= pc_q + 16'd1;
						if (rdata == OPC_BRK || rdata == OPC_ORA_XIND ||
						    rdata == OPC_ORA_ZP || rdata == OPC_ORA_INDY) begin
							case (rdata)
								OPC_BRK:      kind_q <= SEQ_BRK;
								OPC_ORA_XIND: kind_q <= SEQ_ORA_XIND;
								OPC_ORA_ZP:   kind_q <= SEQ_ORA_ZP;
								default:      kind_q <= SEQ_ORA_INDY;
							endcase
							step_q <= 3'd0;
							cyc_q <= cyc_q + 32'd1;
						end else begin
							fault_q <= 1'b1;
							fcode_q <= rdata;
						end
					end else begin
						cyc_q <= cyc_q + 32'd1;
						step_q <= nstep;
						case (kind_q)
							SEQ_RESET: begin
								if (nstep >= 3'd3 && nstep <= 3'd5) sp_q <= sp_q - 8'd1;
								else if (nstep == 3'd6) pc_q <= {8'h00, rdata};
								else if (nstep == 3'd7) begin
									pc_q[15:8] <= rdata;
									kind_q <= SEQ_IDLE; pcross_q <= 1'b0;
								end
							end
							SEQ_BRK: begin
								case (nstep)
									3'd1: pc_q <= pc_q + 16'd1;
									3'd2: begin p_q <= p_q | FLAG_B; sp_q <= sp_q - 8'd1; end
									3'd3: sp_q <= sp_q - 8'd1;
									3'd4: sp_q <= sp_q - 8'd1;
									3'd5: pc_q <= {8'h00, rdata};
									default: begin
										pc_q[15:8] <= rdata;
										kind_q <= SEQ_IDLE; pcross_q <= 1'b0;
									end
								endcase
							end
							SEQ_ORA_ZP, SEQ_ORA_XIND, SEQ_ORA_INDY: begin
								if (nstep == 3'd1) begin
									alat_q <= {8'h00, rdata};
									pc_q <= pc_q + 16'd1;
								end else if (kind_q == SEQ_ORA_XIND && nstep == 3'd2) begin
									alat_q <= {8'h00, alat_q[7:0] + x_q};
								end else if (kind_q == SEQ_ORA_XIND && nstep == 3'd3) begin
									alat_q <= {rdata, alat_q[7:0]};
								end else if (kind_q == SEQ_ORA_XIND && nstep == 3'd4) begin
									alat_q <= {rdata, alat_q[15:8]};
								end else if (kind_q == SEQ_ORA_INDY && nstep == 3'd2) begin
									alat_q <= {rdata, alat_q[7:0]};
								end else if (kind_q == SEQ_ORA_INDY && nstep == 3'd3) begin
									pcross_q <= ({1'b0, alat_q[15:8]} + {1'b0, y_q}) > 9'h0FF;
									alat_q <= {rdata, alat_q[15:8] + y_q};
								end else if (kind_q == SEQ_ORA_INDY && nstep == 3'd4 && pcross_q) begin
									alat_q <= alat_q + 16'h0100;
								end else begin
									acc_q <= acc_q | rdata;
									p_q <= (p_q & ~(FLAG_Z | FLAG_N))
										| (((acc_q | rdata) == 8'h00) ? FLAG_Z : 8'h00)
										| (((acc_q | rdata) & FLAG_N) != 8'h00 ? FLAG_N : 8'h00);
									kind_q <= SEQ_IDLE; pcross_q <= 1'b0;
								end
							end
							default: begin
								kind_q <= SEQ_IDLE; pcross_q <= 1'b0;
							end
						endcase
					end
				end
			end
		end
	end

	assign mem_read_data   = (op_s1 == OP_READ) ? rdata_hold : 8'h00;
	assign prog_count      = pc_q;
	assign accumulator     = acc_q;
	assign stack_ptr       = sp_q;
	assign status_flags    = p_q;
	assign busy_res        = (kind_q != SEQ_IDLE) && !fault_q;
	assign fault           = fault_q;
	assign fault_opcode    = fcode_q;
	assign cycle_count     = cyc_q;

	// Read data is captured when the result is formed, since the memory output
	// register changes on the next access.
	always_ff @(posedge clk) begin
		if (busy_q) rdata_hold <= rdata;
	end
endmodule
`default_nettype wire
